[rtl/bfmd_pkg.sv]
// Shared types and constants for the 2x2 box-filter mip level downscaler.
`timescale 1ns / 1ps

package bfmd_pkg;

    localparam int CH_N  = 4;
    localparam int CH_W  = 8;
    localparam int SUM_W = CH_W + 1;
    localparam int CFG_W = 12;
    localparam int IDX_W = 2;
    localparam int CNT_CFG_W = 3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_SRC_WIDTH     = 2'd0;
    localparam logic [IDX_W-1:0] REG_SRC_HEIGHT    = 2'd1;
    localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [CFG_W-1:0]     RST_SRC_WIDTH     = 12'd2;
    localparam logic [CFG_W-1:0]     RST_SRC_HEIGHT    = 12'd2;
    localparam logic [CNT_CFG_W-1:0] RST_CHANNEL_COUNT = 3'd4;

    typedef logic [CH_W-1:0]  byte_t;
    typedef logic [SUM_W-1:0] sum9_t;

    // How the second stage turns the stored sums into output bytes.
    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_PAIR  = 2'd1,
        MODE_BLOCK = 2'd2
    } avg_mode_t;

    typedef struct packed {
        avg_mode_t                mode;
        logic [CH_N-1:0]          mask;
        logic [CH_N-1:0][SUM_W-1:0] hsum;
    } pair_sum_t;

endpackage

[rtl/bfmd_reduce.sv]
// Final averaging of the stored pair sums into output channel bytes.
`timescale 1ns / 1ps

module bfmd_reduce (
    input  bfmd_pkg::pair_sum_t                               pair_sum,
    input  logic [bfmd_pkg::CH_N-1:0][bfmd_pkg::SUM_W-1:0]    top_sum,
    output logic [bfmd_pkg::CH_N-1:0][bfmd_pkg::CH_W-1:0]     result
);
    import bfmd_pkg::*;

    always_comb begin
        logic [SUM_W:0] block_sum;
        logic [CH_W-1:0] val;
        for (int c = 0; c < CH_N; c++) begin
            block_sum = {1'b0, top_sum[c]} + {1'b0, pair_sum.hsum[c]};
            unique case (pair_sum.mode)
                MODE_PASS:  val = pair_sum.hsum[c][CH_W-1:0];
                MODE_PAIR:  val = pair_sum.hsum[c][SUM_W-1:1];
                MODE_BLOCK: val = block_sum[SUM_W:2];
                default:    val = '0;
            endcase
            result[c] = pair_sum.mask[c] ? val : '0;
        end
    end

endmodule

[rtl/box_filter_mipmap_downscale.sv]
// Top level of the 2x2 box-filter mip level downscaler.
`timescale 1ns / 1ps

// Source pixels enter in raster order at one request per clock while the
// second stage can take them, and each 2x2 block leaves as one averaged
// pixel at the request that brings in its bottom-right source pixel; lines
// and columns of one pixel average pairs. The result then passes the
// second-stage register and the output register. The horizontal pair sums
// of each even row live in a one-write, one-read memory of MAX_WIDTH/2
// entries, read when the odd row's pixel is taken, so a frame needs no
// clearing pass. Writing any configuration register restarts the frame.
module box_filter_mipmap_downscale #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bfmd_pkg::IDX_W-1:0]     cfg_index,
    input  logic [bfmd_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bfmd_pkg::CH_W-1:0]      s_in_ch0,
    input  logic [bfmd_pkg::CH_W-1:0]      s_in_ch1,
    input  logic [bfmd_pkg::CH_W-1:0]      s_in_ch2,
    input  logic [bfmd_pkg::CH_W-1:0]      s_in_ch3,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bfmd_pkg::CH_W-1:0]      m_out_ch0,
    output logic [bfmd_pkg::CH_W-1:0]      m_out_ch1,
    output logic [bfmd_pkg::CH_W-1:0]      m_out_ch2,
    output logic [bfmd_pkg::CH_W-1:0]      m_out_ch3,
    output logic                           m_frame_last
);
    import bfmd_pkg::*;

    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CNT_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = CNT_W + 1;
    localparam int CMP_W   = (CFG_W > DIM_W) ? CFG_W : DIM_W;
    localparam int SLOTS   = MAX_WIDTH / 2;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [CMP_W-1:0] MAXW_C = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0] MAXH_C = CMP_W'(MAX_HEIGHT);

    // Configuration and frame position.
    logic [CFG_W-1:0]     src_width_reg, src_height_reg;
    logic [CNT_CFG_W-1:0] channel_count_reg;
    logic [CNT_W-1:0]     col_reg, col_next;
    logic [CNT_W-1:0]     row_reg, row_next;
    logic [CH_N-1:0][CH_W-1:0] pair_hold_reg, pair_hold_next;

    // Column sum memory.
    logic [CH_N-1:0][SUM_W-1:0] col_mem [SLOTS];
    logic [CH_N-1:0][SUM_W-1:0] top_sum_reg;

    // Second stage and output register.
    logic      s1_valid_reg, s1_valid_next;
    logic      s1_last_reg;
    pair_sum_t s1_data_reg;
    logic      m_valid_reg, m_valid_next;
    logic      m_last_reg;
    logic [CH_N-1:0][CH_W-1:0] m_data_reg;
    logic [CH_N-1:0][CH_W-1:0] reduce_out;

    logic s_accept, s1_adv;
    logic [DIM_W-1:0] img_w, img_h;
    logic [CNT_W-1:0] out_w, out_h;
    logic [CH_N-1:0][CH_W-1:0] pix;
    logic [CH_N-1:0][SUM_W-1:0] hsum;
    logic [SLOT_W-1:0] slot;
    logic emit, emit_last, mem_wr;
    pair_sum_t item_sum;

    assign pix  = {s_in_ch3, s_in_ch2, s_in_ch1, s_in_ch0};
    assign slot = SLOT_W'(col_reg >> 1);

    // Saturate the dimensions to 1..MAX.
    always_comb begin
        logic [CMP_W-1:0] w_ext, h_ext;
        w_ext = CMP_W'(src_width_reg);
        h_ext = CMP_W'(src_height_reg);
        priority if (w_ext == '0) img_w = DIM_W'(1);
        else if (w_ext > MAXW_C)  img_w = DIM_W'(MAXW_C);
        else                      img_w = DIM_W'(w_ext);
        priority if (h_ext == '0) img_h = DIM_W'(1);
        else if (h_ext > MAXH_C)  img_h = DIM_W'(MAXH_C);
        else                      img_h = DIM_W'(h_ext);
    end

    assign out_w = img_w[DIM_W-1:1];
    assign out_h = img_h[DIM_W-1:1];

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        logic [CNT_W-1:0] pos, on;
        logic             wide_one, w_one, h_one;
        logic             supported;
        logic [DIM_W-1:0] col_inc, row_inc;

        w_one    = (img_w == DIM_W'(1));
        h_one    = (img_h == DIM_W'(1));
        wide_one = w_one && h_one;
        pos      = w_one ? row_reg : col_reg;
        on       = w_one ? out_h : out_w;
        supported = (channel_count_reg == 3'd1) || (channel_count_reg == 3'd3) ||
                    (channel_count_reg == 3'd4);

        for (int c = 0; c < CH_N; c++) begin
            hsum[c]          = {1'b0, pair_hold_reg[c]} + {1'b0, pix[c]};
            item_sum.mask[c] = (CNT_CFG_W'(c) < channel_count_reg);
        end
        item_sum.hsum = hsum;
        item_sum.mode = MODE_BLOCK;

        pair_hold_next = pair_hold_reg;
        emit      = 1'b0;
        emit_last = 1'b0;
        mem_wr    = 1'b0;

        priority if (wide_one) begin
            // A single-pixel image passes straight through.
            item_sum.mode = MODE_PASS;
            for (int c = 0; c < CH_N; c++) item_sum.hsum[c] = {1'b0, pix[c]};
            emit      = 1'b1;
            emit_last = 1'b1;
        end else if (w_one || h_one) begin
            item_sum.mode = MODE_PAIR;
            if (!pos[0]) begin
                pair_hold_next = pix;
            end else if ({1'b0, pos} < {on, 1'b0}) begin
                emit      = 1'b1;
                emit_last = ((pos >> 1) == CNT_W'(on - 1'b1));
            end
        end else if (({1'b0, col_reg} < {out_w, 1'b0}) &&
                     ({1'b0, row_reg} < {out_h, 1'b0})) begin
            if (!col_reg[0]) begin
                pair_hold_next = pix;
            end else if (!row_reg[0]) begin
                mem_wr = 1'b1;
            end else if (supported) begin
                emit      = 1'b1;
                emit_last = ((col_reg >> 1) == CNT_W'(out_w - 1'b1)) &&
                            ((row_reg >> 1) == CNT_W'(out_h - 1'b1));
            end
        end

        col_inc  = {1'b0, col_reg} + 1'b1;
        row_inc  = {1'b0, row_reg} + 1'b1;
        col_next = CNT_W'(col_inc);
        row_next = row_reg;
        if (col_inc >= img_w) begin
            col_next = '0;
            row_next = (row_inc >= img_h) ? '0 : CNT_W'(row_inc);
        end
    end

    // Configuration and frame position; a write to any of the three registers abandons the frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg     <= RST_SRC_WIDTH;
            src_height_reg    <= RST_SRC_HEIGHT;
            channel_count_reg <= RST_CHANNEL_COUNT;
            col_reg           <= '0;
            row_reg           <= '0;
            pair_hold_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SRC_WIDTH:     src_width_reg     <= cfg_wdata;
                REG_SRC_HEIGHT:    src_height_reg    <= cfg_wdata;
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata[CNT_CFG_W-1:0];
                default: ;
            endcase
            if (cfg_index == REG_SRC_WIDTH || cfg_index == REG_SRC_HEIGHT ||
                cfg_index == REG_CHANNEL_COUNT) begin
                col_reg       <= '0;
                row_reg       <= '0;
                pair_hold_reg <= '0;
            end
        end else if (s_accept) begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            pair_hold_reg <= pair_hold_next;
        end
    end

    // Even rows store their pair sums; odd rows read them back at the same slot.
    always_ff @(posedge aclk) begin
        if (s_accept && mem_wr) begin
            col_mem[slot] <= hsum;
        end
        if (s_accept) begin
            top_sum_reg <= col_mem[slot];
        end
    end

    assign s1_valid_next = s_accept ? emit : (s1_valid_reg && !s1_adv);
    assign m_valid_next  = s1_adv || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_data_reg <= item_sum;
            s1_last_reg <= emit_last;
        end
        if (s1_adv) begin
            m_data_reg <= reduce_out;
            m_last_reg <= s1_last_reg;
        end
    end

    bfmd_reduce u_reduce (
        .pair_sum (s1_data_reg),
        .top_sum  (top_sum_reg),
        .result   (reduce_out)
    );

    assign m_valid      = m_valid_reg;
    assign m_out_ch0    = m_data_reg[0];
    assign m_out_ch1    = m_data_reg[1];
    assign m_out_ch2    = m_data_reg[2];
    assign m_out_ch3    = m_data_reg[3];
    assign m_frame_last = m_last_reg;

endmodule
